// ===== rtl/gwr_pkg.sv =====
// Shared constants, codes and types of the grid wall ray caster.
package gwr_pkg;

   localparam int MAP_SIDE    = 64;
   localparam int MAP_BITS    = 6;
   localparam int CELL_BITS   = 2 * MAP_BITS;
   localparam int CELL_COUNT  = MAP_SIDE * MAP_SIDE;
   localparam int FRAC_BITS   = 10;
   localparam int POS_W       = 16;
   localparam int ANGLE_BITS  = 12;
   localparam int PHASE_BITS  = 16;
   localparam int PHASE_SHIFT = PHASE_BITS - ANGLE_BITS;
   localparam int QUARTER_W   = 15;
   localparam int DIR_W       = 12;
   localparam int LINE_W      = 8;
   localparam int OFS_W       = 19;
   localparam int COORD_W     = 30;
   localparam int NUM_W       = 28;
   localparam int DEN_W       = 11;
   localparam int MUL_A_W     = 32;
   localparam int MUL_B_W     = 20;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int RAD_W       = 36;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int DIST_SHIFT  = FRAC_BITS - 9;
   localparam int DIST_W      = 16;
   localparam int TEX_W       = 10;
   localparam int CROSS_LIMIT = 2 * MAP_SIDE + 4;
   localparam int CROSS_W     = 8;
   localparam int CSR_W       = 7;
   localparam int REQ_W       = 64;
   localparam int RSP_W       = 32;
   localparam int SIN_LAST    = 5;

   localparam logic [31:0] SIN_C1 = 32'd1686629713;
   localparam logic [31:0] SIN_C3 = 32'd693598669;
   localparam logic [31:0] SIN_C5 = 32'd85569306;
   localparam logic [31:0] SIN_C7 = 32'd5026995;
   localparam logic [31:0] SIN_C9 = 32'd172272;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TRACE = 1'b1;
   localparam logic CSR_MAP_COLUMNS = 1'b0;
   localparam logic CSR_MAP_ROWS    = 1'b1;
   localparam logic STATUS_HIT = 1'b0;
   localparam logic STATUS_OOB = 1'b1;
   localparam logic [1:0] FACE_NORTH = 2'd0;
   localparam logic [1:0] FACE_EAST  = 2'd1;
   localparam logic [1:0] FACE_SOUTH = 2'd2;
   localparam logic [1:0] FACE_WEST  = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE, OP_CLEAR, OP_WRITE, OP_LOAD, OP_SINE, OP_INIT, OP_DIST, OP_MUL_A,
      OP_MUL_B, OP_MUL_N, OP_DIV_GO, OP_ADVANCE, OP_HIT, OP_SQ_A, OP_SQ_B, OP_ROOT_GO
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_SINE, ST_INIT, ST_DIST, ST_MUL_A, ST_MUL_B, ST_MUL_N,
      ST_DIV_GO, ST_DIV, ST_CHECK, ST_READ, ST_GIVE_UP, ST_SQ_A, ST_SQ_B,
      ST_ROOT_GO, ST_ROOT, ST_DONE
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] sin_step;
      logic       sin_cos;
      logic       set_oob;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_done;
      logic root_done;
      logic oob;
      logic wall;
   } stat_type;

   function automatic logic [31:0] sin_coef(input logic [2:0] step);
      case (step)
         3'd1:    return SIN_C7;
         3'd2:    return SIN_C5;
         3'd3:    return SIN_C3;
         default: return SIN_C1;
      endcase
   endfunction

endpackage

// ===== rtl/gwr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gwr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gwr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module gwr_div import gwr_pkg::*; #(
   parameter int N = NUM_W,
   parameter int D = DEN_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient,
   output logic         rem_nonzero
);

   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  quo_ff, quo_in;
   logic [D-1:0]  rem_ff, rem_in, den_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          active_ff, active_in, done_ff, done_in;
   logic [D:0]    shifted;
   logic          fits;

   always_comb begin
      shifted   = {rem_ff, quo_ff[N-1]};
      fits      = shifted >= {1'b0, den_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in    = dividend;
         rem_in    = '0;
         cnt_in    = CW'(N);
         active_in = 1'b1;
      end else if (active_ff) begin
         rem_in = fits ? D'(shifted - {1'b0, den_ff}) : shifted[D-1:0];
         quo_in = {quo_ff[N-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done        = done_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = rem_ff != '0;

endmodule

// ===== rtl/gwr_sqrt.sv =====
// Bit-pair integer square root, one root bit per cycle.
module gwr_sqrt import gwr_pkg::*; #(
   parameter int N = RAD_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N-1:0]   radicand,
   output logic           done,
   output logic [N/2-1:0] root
);

   localparam int R  = N / 2;
   localparam int CW = $clog2(R + 1);

   logic [N-1:0]  rad_ff, rad_in;
   logic [R+1:0]  rem_ff, rem_in;
   logic [R-1:0]  root_ff, root_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          active_ff, active_in, done_ff, done_in;
   logic [R+3:0]  pulled, trial;

   always_comb begin
      pulled    = {rem_ff, rad_ff[N-1:N-2]};
      trial     = {2'b00, root_ff, 2'b01};
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rad_in    = radicand;
         rem_in    = '0;
         root_in   = '0;
         cnt_in    = CW'(R);
         active_in = 1'b1;
      end else if (active_ff) begin
         rad_in = {rad_ff[N-3:0], 2'b00};
         if (pulled >= trial) begin
            rem_in  = (R+2)'(pulled - trial);
            root_in = {root_ff[R-2:0], 1'b1};
         end else begin
            rem_in  = pulled[R+1:0];
            root_in = {root_ff[R-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/gwr_datapath.sv =====
// Datapath: map RAM, direction polynomial, grid-line stepping, divider and root.
module gwr_datapath import gwr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tuser
);

   // request fields
   logic [MAP_BITS-1:0]   f_col, f_row;
   logic                  f_wall;
   logic [POS_W-1:0]      f_x, f_y;
   logic [ANGLE_BITS-1:0] f_ang;

   assign f_col  = req_tdata[5:0];
   assign f_row  = req_tdata[11:6];
   assign f_wall = req_tdata[12];
   assign f_x    = req_tdata[28:13];
   assign f_y    = req_tdata[44:29];
   assign f_ang  = req_tdata[56:45];

   logic [CSR_W-1:0]       cols_ff, rows_ff;
   logic [CELL_BITS-1:0]   clr_ff;
   logic [POS_W-1:0]       px_ff, py_ff;
   logic [ANGLE_BITS-1:0]  ang_ff;
   logic signed [DIR_W-1:0] dirx_ff, diry_ff;
   logic [QUARTER_W-1:0]   u_ff, u2_ff;
   logic [31:0]            p_ff;
   logic                   sneg_ff;
   logic signed [LINE_W-1:0] vline_ff, hline_ff;
   logic signed [OFS_W-1:0]  dxv_ff, dyh_ff, ox_ff, oy_ff;
   logic [PROD_W-1:0]      pa_ff;
   logic                   vert_ff;
   logic signed [NUM_W:0]  num_ff;
   logic                   qneg_ff;
   logic signed [COORD_W-1:0] coord_ff;
   logic [RAD_W-1:0]       sq_ff, rad_ff;
   logic [1:0]             face_ff;
   logic [FRAC_BITS:0]     tex_ff;
   logic [DIST_W-1:0]      dist_ff;
   logic                   oob_ff;
   logic [DIST_W-1:0]      out_dist_ff;
   logic [1:0]             out_face_ff;
   logic [TEX_W-1:0]       out_tex_ff;
   logic                   out_stat_ff;

   logic xpos, xneg, xzero, ypos, yneg, yzero;
   assign xneg  = dirx_ff[DIR_W-1];
   assign xzero = dirx_ff == '0;
   assign xpos  = !xneg && !xzero;
   assign yneg  = diry_ff[DIR_W-1];
   assign yzero = diry_ff == '0;
   assign ypos  = !yneg && !yzero;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic [PHASE_BITS-1:0]     phase;
   logic [QUARTER_W-1:0]      uq, vq;
   logic [OFS_W-1:0]          dxv_abs, dyh_abs;
   logic [DIR_W-1:0]          dirx_abs, diry_abs;
   logic [37:0]               sround;
   logic [DEN_W:0]            s_mag;

   always_comb begin
      phase = {ang_ff, {PHASE_SHIFT{1'b0}}};
      if (cmd.sin_cos) begin
         phase = phase + PHASE_BITS'(16384);
      end
      uq = {1'b0, phase[13:0]};
      vq = phase[14] ? QUARTER_W'(15'd16384 - uq) : uq;
      dxv_abs  = dxv_ff[OFS_W-1] ? OFS_W'(-dxv_ff) : OFS_W'(dxv_ff);
      dyh_abs  = dyh_ff[OFS_W-1] ? OFS_W'(-dyh_ff) : OFS_W'(dyh_ff);
      dirx_abs = xneg ? DIR_W'(-dirx_ff) : DIR_W'(dirx_ff);
      diry_abs = yneg ? DIR_W'(-diry_ff) : DIR_W'(diry_ff);
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SINE: begin
            if (cmd.sin_step == 3'd0) begin
               mul_a = MUL_A_W'(vq);
               mul_b = MUL_B_W'(vq);
            end else if (cmd.sin_step == 3'(SIN_LAST)) begin
               mul_a = MUL_A_W'(p_ff);
               mul_b = MUL_B_W'(u_ff);
            end else if (cmd.sin_step == 3'd1) begin
               mul_a = MUL_A_W'(SIN_C9);
               mul_b = MUL_B_W'(u2_ff);
            end else begin
               mul_a = MUL_A_W'(p_ff);
               mul_b = MUL_B_W'(u2_ff);
            end
         end
         OP_MUL_A: begin
            mul_a = MUL_A_W'(dxv_abs);
            mul_b = MUL_B_W'(diry_abs);
         end
         OP_MUL_B: begin
            mul_a = MUL_A_W'(dyh_abs);
            mul_b = MUL_B_W'(dirx_abs);
         end
         OP_MUL_N: begin
            mul_a = vert_ff ? MUL_A_W'(dxv_ff) : MUL_A_W'(dyh_ff);
            mul_b = vert_ff ? MUL_B_W'(diry_ff) : MUL_B_W'(dirx_ff);
         end
         OP_SQ_A: begin
            mul_a = MUL_A_W'(ox_ff);
            mul_b = MUL_B_W'(ox_ff);
         end
         OP_SQ_B: begin
            mul_a = MUL_A_W'(oy_ff);
            mul_b = MUL_B_W'(oy_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod   = mul_a * mul_b;
      sround = prod[51:14] + 38'd524288;
      s_mag  = sround[31:20];
   end

   // divider
   logic              div_done, div_nz;
   logic [NUM_W-1:0]  div_q, num_abs;
   logic [DEN_W-1:0]  den_abs;
   logic signed [COORD_W-1:0] q_floor, coord_in;

   assign num_abs = num_ff[NUM_W] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign den_abs = vert_ff ? dirx_abs[DEN_W-1:0] : diry_abs[DEN_W-1:0];
   assign q_floor = qneg_ff ? COORD_W'(-(COORD_W'(div_q) + COORD_W'(div_nz)))
                            : COORD_W'(div_q);
   assign coord_in = (vert_ff ? COORD_W'(py_ff) : COORD_W'(px_ff)) + q_floor;

   gwr_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.op == OP_DIV_GO),
      .dividend    (num_abs),
      .divisor     (den_abs),
      .done        (div_done),
      .quotient    (div_q),
      .rem_nonzero (div_nz)
   );

   // root
   logic              root_done;
   logic [ROOT_W-1:0] root;
   logic [ROOT_W-1:0] dist_full;

   assign dist_full = root >> DIST_SHIFT;

   gwr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_ROOT_GO),
      .radicand (rad_ff),
      .done     (root_done),
      .root     (root)
   );

   // crossing check
   logic signed [COORD_W-1:0] cflo, mx, my, cell_idx, cols_eff, rows_eff;
   logic                      oob;
   logic [CELL_BITS-1:0]      rd_addr, wr_addr;
   logic                      wr_en, wr_data, rd_data;

   always_comb begin
      cflo     = coord_ff >>> FRAC_BITS;
      cols_eff = cols_ff > CSR_W'(MAP_SIDE) ? COORD_W'(MAP_SIDE) : COORD_W'(cols_ff);
      rows_eff = rows_ff > CSR_W'(MAP_SIDE) ? COORD_W'(MAP_SIDE) : COORD_W'(rows_ff);
      if (vert_ff) begin
         mx       = COORD_W'(vline_ff);
         my       = cflo;
         cell_idx = mx - COORD_W'(xneg);
         rd_addr  = {my[MAP_BITS-1:0], cell_idx[MAP_BITS-1:0]};
      end else begin
         mx       = cflo;
         my       = COORD_W'(hline_ff);
         cell_idx = my - COORD_W'(yneg);
         rd_addr  = {cell_idx[MAP_BITS-1:0], mx[MAP_BITS-1:0]};
      end
      oob = mx < 0 || mx >= cols_eff || my < 0 || my >= rows_eff || cell_idx < 0;
      wr_en   = cmd.op == OP_CLEAR || cmd.op == OP_WRITE;
      wr_addr = cmd.op == OP_CLEAR ? clr_ff : {f_row, f_col};
      wr_data = cmd.op == OP_CLEAR ? 1'b0 : f_wall;
   end

   gwr_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.clear_last = clr_ff == '1;
      stat.div_done   = div_done;
      stat.root_done  = root_done;
      stat.oob        = oob;
      stat.wall       = rd_data;
   end

   logic [FRAC_BITS-1:0] frac;
   assign frac = coord_ff[FRAC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= CSR_W'(MAP_SIDE);
         rows_ff <= CSR_W'(MAP_SIDE);
         clr_ff  <= '0;
      end else begin
         if (csr_we && csr_index == CSR_MAP_COLUMNS) begin
            cols_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_MAP_ROWS) begin
            rows_ff <= csr_wdata;
         end
         if (cmd.op == OP_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
      if (div_done) begin
         coord_ff <= coord_in;
      end
      if (root_done) begin
         dist_ff <= dist_full > ROOT_W'(16'hFFFF) ? 16'hFFFF : dist_full[DIST_W-1:0];
      end
      if (cmd.set_oob) begin
         oob_ff <= 1'b1;
      end
      if (cmd.emit) begin
         out_stat_ff <= oob_ff;
         out_dist_ff <= oob_ff ? '0 : dist_ff;
         out_face_ff <= oob_ff ? '0 : face_ff;
         out_tex_ff  <= oob_ff ? '0 :
                        (tex_ff[FRAC_BITS] ? '1 : tex_ff[TEX_W-1:0]);
      end
      case (cmd.op)
         OP_LOAD: begin
            px_ff  <= f_x;
            py_ff  <= f_y;
            ang_ff <= f_ang;
            oob_ff <= 1'b0;
         end
         OP_SINE: begin
            if (cmd.sin_step == 3'd0) begin
               u_ff    <= vq;
               u2_ff   <= prod[28:14];
               sneg_ff <= phase[15] ^ !cmd.sin_cos;
            end else if (cmd.sin_step == 3'(SIN_LAST)) begin
               if (cmd.sin_cos) begin
                  dirx_ff <= sneg_ff ? DIR_W'(-s_mag) : DIR_W'(s_mag);
               end else begin
                  diry_ff <= sneg_ff ? DIR_W'(-s_mag) : DIR_W'(s_mag);
               end
            end else begin
               p_ff <= sin_coef(cmd.sin_step) - prod[45:14];
            end
         end
         OP_INIT: begin
            vline_ff <= LINE_W'(px_ff[POS_W-1:FRAC_BITS]) + LINE_W'(xpos);
            hline_ff <= LINE_W'(py_ff[POS_W-1:FRAC_BITS]) + LINE_W'(ypos);
         end
         OP_DIST: begin
            // lines may sit at -1, so extend with sign before scaling
            dxv_ff <= (OFS_W'(vline_ff) <<< FRAC_BITS) - OFS_W'(px_ff);
            dyh_ff <= (OFS_W'(hline_ff) <<< FRAC_BITS) - OFS_W'(py_ff);
         end
         OP_MUL_A: begin
            pa_ff <= prod;
         end
         OP_MUL_B: begin
            vert_ff <= xzero ? 1'b0 : (yzero ? 1'b1 : pa_ff < PROD_W'(prod));
         end
         OP_MUL_N: begin
            num_ff <= (NUM_W+1)'(prod);
         end
         OP_DIV_GO: begin
            qneg_ff <= num_ff[NUM_W] ^ (vert_ff ? xneg : yneg);
         end
         OP_ADVANCE: begin
            if (vert_ff) begin
               vline_ff <= xpos ? vline_ff + 1'b1 : vline_ff - 1'b1;
            end else begin
               hline_ff <= ypos ? hline_ff + 1'b1 : hline_ff - 1'b1;
            end
         end
         OP_HIT: begin
            if (vert_ff) begin
               tex_ff  <= xpos ? (FRAC_BITS+1)'((1 << FRAC_BITS) - frac) : {1'b0, frac};
               face_ff <= xpos ? FACE_EAST : FACE_WEST;
               ox_ff   <= dxv_ff;
               oy_ff   <= OFS_W'(coord_ff - COORD_W'(py_ff));
            end else begin
               tex_ff  <= yneg ? (FRAC_BITS+1)'((1 << FRAC_BITS) - frac) : {1'b0, frac};
               face_ff <= ypos ? FACE_SOUTH : FACE_NORTH;
               ox_ff   <= OFS_W'(coord_ff - COORD_W'(px_ff));
               oy_ff   <= dyh_ff;
            end
         end
         OP_SQ_A: begin
            sq_ff <= RAD_W'(prod);
         end
         OP_SQ_B: begin
            rad_ff <= sq_ff + RAD_W'(prod);
         end
         default: begin
         end
      endcase
   end

   assign rsp_tdata = {4'b0000, out_tex_ff, out_face_ff, out_dist_ff};
   assign rsp_tuser = out_stat_ff;

endmodule

// ===== rtl/gwr_ctrl.sv =====
// Controller: sequences map clearing, cell writes and ray traces.
module gwr_ctrl import gwr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     req_command,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type          state_ff, state_in;
   logic [2:0]         sin_cnt_ff, sin_cnt_in;
   logic               sin_cos_ff, sin_cos_in;
   logic [CROSS_W-1:0] cross_ff, cross_in;
   logic               valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         sin_cnt_ff <= '0;
         sin_cos_ff <= 1'b0;
         cross_ff   <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sin_cnt_ff <= sin_cnt_in;
         sin_cos_ff <= sin_cos_in;
         cross_ff   <= cross_in;
         valid_ff   <= valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sin_cnt_in   = sin_cnt_ff;
      sin_cos_in   = sin_cos_ff;
      cross_in     = cross_ff;
      valid_in     = valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd.op       = OP_NONE;
      cmd.sin_step = sin_cnt_ff;
      cmd.sin_cos  = sin_cos_ff;
      cmd.set_oob  = 1'b0;
      cmd.emit     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_command == CMD_TRACE) begin
                  cmd.op     = OP_LOAD;
                  sin_cnt_in = '0;
                  sin_cos_in = 1'b1;
                  state_in   = ST_SINE;
               end else begin
                  cmd.op = OP_WRITE;
               end
            end
         end
         ST_SINE: begin
            cmd.op = OP_SINE;
            if (sin_cnt_ff == 3'(SIN_LAST)) begin
               sin_cnt_in = '0;
               if (sin_cos_ff) begin
                  sin_cos_in = 1'b0;
               end else begin
                  state_in = ST_INIT;
               end
            end else begin
               sin_cnt_in = sin_cnt_ff + 1'b1;
            end
         end
         ST_INIT: begin
            cmd.op   = OP_INIT;
            cross_in = '0;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            cmd.op   = OP_DIST;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.op   = OP_MUL_A;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.op   = OP_MUL_B;
            state_in = ST_MUL_N;
         end
         ST_MUL_N: begin
            cmd.op   = OP_MUL_N;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.op   = OP_DIV_GO;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.oob) begin
               cmd.set_oob = 1'b1;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (stat.wall) begin
               cmd.op   = OP_HIT;
               state_in = ST_SQ_A;
            end else begin
               cmd.op = OP_ADVANCE;
               if (cross_ff == CROSS_W'(CROSS_LIMIT - 1)) begin
                  state_in = ST_GIVE_UP;
               end else begin
                  cross_in = cross_ff + 1'b1;
                  state_in = ST_DIST;
               end
            end
         end
         ST_GIVE_UP: begin
            cmd.set_oob = 1'b1;
            state_in    = ST_DONE;
         end
         ST_SQ_A: begin
            cmd.op   = OP_SQ_A;
            state_in = ST_SQ_B;
         end
         ST_SQ_B: begin
            cmd.op   = OP_SQ_B;
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            cmd.op   = OP_ROOT_GO;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (stat.root_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ===== rtl/grid_wall_raycaster.sv =====
// Grid wall ray caster top level.
//
// req channel: one word per command. tuser = command (write cell / trace ray).
// A cell write does not drop req_tready and yields no rsp word. A trace yields
// exactly one rsp word: distance, wall face and texture offset in tdata,
// tuser high when the ray left the map (all tdata fields then zero).
// A trace first evaluates the direction polynomial, then for each grid line
// crossed runs one divide for the crossing coordinate plus a map RAM read,
// then the square root for the distance.
// Only one trace is in flight; req_tready is high only while idle.
// The rsp word sits in an output register, so a new req word is taken while
// a finished result still waits; a trace that finishes while that register
// is full holds until rsp_tready frees it.
// Reset clears the wall map with a sweep over all 4096 cells, one cell a cycle;
// req_tready stays low until it ends. csr writes are taken at any time,
// but should be made only while idle.
module grid_wall_raycaster import gwr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // cell_column, cell_row, cell_is_wall, viewer_x,
                                        // viewer_y, ray_angle, zero fill
   input  logic             req_tuser,  // command
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // hit_distance, wall_face, texture_offset, zero fill
   output logic             rsp_tuser,  // status
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   gwr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .stat        (stat)
   );

   gwr_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== rtl/gwr_checker.sv =====
// Port-level checker for the grid wall ray caster, with its bind.
module gwr_checker import gwr_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_clear_busy: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("req taken during map clear");

   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_OOB |-> rsp_tdata == '0)
      else $error("out-of-map word carries data");

   a_trace_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_TRACE |=> !req_tready)
      else $error("req taken during trace");

   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_WRITE |=> req_tready)
      else $error("cell write stalled the channel");

endmodule

bind grid_wall_raycaster gwr_checker u_gwr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/gwr_checker.sv =====
// Ray caster checker: mirrors the wall map, predicts each trace and compares rsp words.
`timescale 1ns / 1ps
module gwr_tb_checker import gwr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tuser,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               errors,
   output int               pending
);

   typedef struct packed {
      logic [15:0] distance;
      logic [1:0]  face;
      logic [9:0]  tex;
      logic        status;
   } ray_result_t;

   bit            wall_bits [CELL_COUNT];
   int            used_cols;
   int            used_rows;
   ray_result_t   pending_hits [$];

   assign pending = pending_hits.size();

   function automatic longint quarter_wave_sine(longint u);
      longint u2, p;
      u2 = (u * u) >>> 14;
      p  = longint'(SIN_C7) - ((longint'(SIN_C9) * u2) >>> 14);
      p  = longint'(SIN_C5) - ((p * u2) >>> 14);
      p  = longint'(SIN_C3) - ((p * u2) >>> 14);
      p  = longint'(SIN_C1) - ((p * u2) >>> 14);
      return (((p * u) >>> 14) + (longint'(1) << 19)) >>> 20;
   endfunction

   function automatic longint heading_sine(longint phase);
      longint u;
      u = phase & 'h3FFF;
      case ((phase >> 14) & 3)
         0:       return quarter_wave_sine(u);
         1:       return quarter_wave_sine(16384 - u);
         2:       return -quarter_wave_sine(u);
         default: return -quarter_wave_sine(16384 - u);
      endcase
   endfunction

   function automatic longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
      return q;
   endfunction

   function automatic longint abs_of(longint a);
      return a < 0 ? -a : a;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic ray_result_t wall_hit(longint ox, longint oy, longint tex,
                                            logic [1:0] face);
      ray_result_t r;
      longint unsigned d;
      d = int_sqrt(longint'(ox * ox) + longint'(oy * oy)) >> 1;
      r.distance = d > 65535 ? 16'hFFFF : d[15:0];
      r.face     = face;
      r.tex      = tex > 1023 ? 10'd1023 : tex[9:0];
      r.status   = STATUS_HIT;
      return r;
   endfunction

   function automatic ray_result_t cast_ray(longint px, longint py, longint ang);
      ray_result_t r;
      longint one, phase, dx, dy, sx, sy, vline, hline, cols, rows;
      longint dxv, dyh, ny, nx, mx, my, cell_no;
      bit vert;
      one = 1024;
      r = '0;
      r.status = STATUS_OOB;
      phase = (ang * 16) & 'hFFFF;
      dx = heading_sine((phase + 16384) & 'hFFFF);
      dy = -heading_sine(phase);
      sx = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
      sy = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
      cols = used_cols > MAP_SIDE ? MAP_SIDE : used_cols;
      rows = used_rows > MAP_SIDE ? MAP_SIDE : used_rows;
      vline = (px >>> 10) + (sx > 0 ? 1 : 0);
      hline = (py >>> 10) + (sy > 0 ? 1 : 0);
      for (int n = 0; n < CROSS_LIMIT; n++) begin
         dxv = 0; dyh = 0; ny = 0; nx = 0;
         if (sx != 0) begin
            dxv = vline * one - px;
            ny  = py + floor_quot(dy * dxv, dx);
         end
         if (sy != 0) begin
            dyh = hline * one - py;
            nx  = px + floor_quot(dx * dyh, dy);
         end
         if (sx == 0) vert = 0;
         else if (sy == 0) vert = 1;
         else vert = abs_of(dxv) * abs_of(dy) < abs_of(dyh) * abs_of(dx);
         if (vert) begin
            mx = vline;
            my = floor_quot(ny, one);
            cell_no = mx - (sx < 0 ? 1 : 0);
            if (mx < 0 || mx >= cols || my < 0 || my >= rows || cell_no < 0) return r;
            if (wall_bits[my * MAP_SIDE + cell_no])
               return wall_hit(dxv, ny - py,
                               sx > 0 ? one - (ny - my * one) : ny - my * one,
                               sx > 0 ? FACE_EAST : FACE_WEST);
            vline = vline + sx;
         end else begin
            mx = floor_quot(nx, one);
            my = hline;
            cell_no = my - (sy < 0 ? 1 : 0);
            if (mx < 0 || mx >= cols || my < 0 || my >= rows || cell_no < 0) return r;
            if (wall_bits[cell_no * MAP_SIDE + mx])
               return wall_hit(nx - px, dyh,
                               sy < 0 ? one - (nx - mx * one) : nx - mx * one,
                               sy > 0 ? FACE_SOUTH : FACE_NORTH);
            hline = hline + sy;
         end
      end
      return r;
   endfunction

   initial errors = 0;

   always @(posedge clock) begin
      ray_result_t want, got;
      if (reset) begin
         foreach (wall_bits[i]) wall_bits[i] = 0;
         used_cols = 64;
         used_rows = 64;
         pending_hits.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MAP_COLUMNS) used_cols = csr_wdata;
            else used_rows = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_WRITE)
               wall_bits[req_tdata[11:6] * MAP_SIDE + req_tdata[5:0]] = req_tdata[12];
            else
               pending_hits.push_back(cast_ray(req_tdata[28:13], req_tdata[44:29],
                                               req_tdata[56:45]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[17:16], rsp_tdata[27:18], rsp_tuser};
            if (pending_hits.size() == 0) begin
               $display("%0t: rsp word with nothing expected: %h", $time, got);
               errors++;
            end else begin
               want = pending_hits.pop_front();
               if (got.distance !== want.distance || got.face !== want.face ||
                   got.tex !== want.tex || got.status !== want.status) begin
                  $display("%0t: mismatch exp dist %0d face %0d tex %0d status %0d",
                           $time, want.distance, want.face, want.tex, want.status);
                  $display("%0t:          got dist %0d face %0d tex %0d status %0d",
                           $time, got.distance, got.face, got.tex, got.status);
                  errors++;
               end
            end
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
// Ray caster testbench top: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;
   import gwr_pkg::*;

   localparam longint CYCLE_LIMIT = 8_000_000;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tuser = CMD_WRITE;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_we = 0;
   logic             csr_index = CSR_MAP_COLUMNS;
   logic [CSR_W-1:0] csr_wdata = '0;
   int               errors, pending;
   bit               quiet = 0;
   int               stall_left = 0;
   longint           cycles = 0;
   int               traces = 0, writes = 0;
   int               cols_now = 64, rows_now = 64;

   grid_wall_raycaster dut (.*);

   gwr_tb_checker checker_i (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1;
      end else if (stall_left > 0) begin
         rsp_tready <= 0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 4) begin
         rsp_tready <= 0;
         stall_left <= $urandom_range(20, 120);
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= 25;
      end
   end

   task automatic send_word(logic cmd, logic [5:0] col, logic [5:0] row, logic wall,
                            logic [15:0] vx, logic [15:0] vy, logic [11:0] ang);
      int gap, roll;
      roll = $urandom_range(0, 99);
      gap = quiet ? 0 : (roll < 60 ? 0 : (roll < 94 ? $urandom_range(1, 4)
                                                     : $urandom_range(10, 60)));
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, ang, vy, vx, wall, row, col};
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      if (cmd == CMD_TRACE) traces++;
      else writes++;
   endtask

   task automatic put_cell(int col, int row, bit wall);
      send_word(CMD_WRITE, 6'(col), 6'(row), wall, 16'($urandom), 16'($urandom),
                12'($urandom));
   endtask

   task automatic trace(int vx, int vy, int ang);
      send_word(CMD_TRACE, 6'($urandom), 6'($urandom), 1'($urandom), 16'(vx), 16'(vy),
                12'(ang));
   endtask

   // Map size change only once the block has drained.
   task automatic set_map(int cols, int rows);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_we    <= 1;
      csr_index <= CSR_MAP_COLUMNS;
      csr_wdata <= CSR_W'(cols);
      @(posedge clock);
      csr_index <= CSR_MAP_ROWS;
      csr_wdata <= CSR_W'(rows);
      @(posedge clock);
      csr_we <= 0;
      cols_now = cols > 64 ? 64 : cols;
      rows_now = rows > 64 ? 64 : rows;
   endtask

   task automatic random_words(int count);
      int span_x, span_y, ang;
      span_x = cols_now * 1024 + 1023;
      span_y = rows_now * 1024 + 1023;
      if (span_x > 65535) span_x = 65535;
      if (span_y > 65535) span_y = 65535;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 40) begin
            put_cell($urandom_range(0, cols_now < 64 ? cols_now : 63),
                     $urandom_range(0, rows_now < 64 ? rows_now : 63),
                     $urandom_range(0, 99) < 60);
         end else begin
            ang = $urandom_range(0, 99) < 15 ? 512 * $urandom_range(0, 7)
                                               : $urandom_range(0, 4095);
            if ($urandom_range(0, 99) < 80)
               trace($urandom_range(0, span_x), $urandom_range(0, span_y), ang);
            else
               trace($urandom_range(0, 65535), $urandom_range(0, 65535), ang);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      quiet = 1;

      // directed: empty map, corners, axes, diagonals, zero distance, leaving the map
      trace(0, 0, 0);
      trace(65535, 65535, 4095);
      put_cell(0, 0, 1);
      put_cell(63, 63, 1);
      put_cell(9, 10, 1);
      trace(10240, 10752, 2048);
      trace(512, 2560, 1024);
      trace(63 * 1024 + 512, 60 * 1024, 3072);
      trace(512, 512, 512);
      trace(62 * 1024 + 512, 62 * 1024 + 512, 3584);
      trace(20 * 1024, 20 * 1024, 2560);
      trace(65535, 0, 2048);
      trace(0, 65535, 1024);
      trace(5 * 1024 + 1023, 10 * 1024 + 300, 0);
      put_cell(9, 10, 0);
      trace(10240, 10752, 2048);
      put_cell(63, 0, 1);
      trace(32768, 512, 0);
      set_map(1, 1);
      trace(512, 512, 1536);
      trace(0, 0, 3000);
      set_map(127, 127);
      trace(100, 100, 2500);
      quiet = 0;

      random_words(80);
      set_map(16, 16);
      random_words(80);
      set_map(127, 3);
      random_words(60);
      set_map(8, 40);
      quiet = 1;
      random_words(60);
      quiet = 0;
      set_map(1, 1);
      random_words(30);
      set_map(5, 64);
      random_words(70);
      set_map(64, 64);
      random_words(70);
      set_map($urandom_range(1, 127), $urandom_range(1, 127));
      random_words(100);

      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d ray traces and %0d cell writes over nine map sizes,", traces,
               writes);
      $display("with random gaps and stalls on both channels");
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gwr_pkg.sv
rtl/gwr_ram.sv
rtl/gwr_div.sv
rtl/gwr_sqrt.sv
rtl/gwr_datapath.sv
rtl/gwr_ctrl.sv
rtl/grid_wall_raycaster.sv
rtl/gwr_checker.sv
tb/gwr_checker.sv
tb/testbench.sv
